@@ rtl/core/ndrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ndrt_pkg: shared types and constants for the reverse-transpose address block
// Register indexes, fixed field widths, extent clamping and the control bundle
// passed from the configuration unit to the address walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ndrt_pkg;

    // Fixed widths of the configuration fields
    localparam int NUM_AXES   = 4;
    localparam int RANK_BITS  = 3;
    localparam int SIZE_BITS  = 11;
    localparam int IDX_BITS   = 10;
    localparam int CIDX_BITS  = 3;
    localparam logic [SIZE_BITS-1:0] MAX_EXTENT = 11'd1024;

    // Parameter defaults
    localparam int DEF_MAX_RANK     = 4;
    localparam int DEF_ADDR_BITS    = 20;
    localparam int DEF_ELEMENT_BITS = 32;

    // Configuration register indexes
    localparam logic [CIDX_BITS-1:0] REG_RANK  = 3'd0;
    localparam logic [CIDX_BITS-1:0] REG_AXIS0 = 3'd1;
    localparam logic [CIDX_BITS-1:0] REG_AXIS1 = 3'd2;
    localparam logic [CIDX_BITS-1:0] REG_AXIS2 = 3'd3;
    localparam logic [CIDX_BITS-1:0] REG_AXIS3 = 3'd4;

    // Control bundle from the configuration unit to the walker
    typedef struct packed {
        logic                 busy;
        logic                 restart;
        logic                 out_of_range;
        logic [RANK_BITS-1:0] rank;
    } ndrt_ctrl_t;

    // Clamp a written size to 1..1024 and return extent minus one
    function automatic logic [IDX_BITS-1:0] ext_m1_f(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] c;
        begin
            c = v;
            if (c == '0) begin
                c = 11'd1;
            end
            if (c > MAX_EXTENT) begin
                c = MAX_EXTENT;
            end
            ext_m1_f = IDX_BITS'(c - 11'd1);
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ndrt_cfg.sv @@
// ----------------------------------------------------------------------------
// ndrt_cfg: configuration registers and stride setup sequencer
// Holds rank and extents, and after reset or any write to a listed register
// steps through the axes, one multiply per cycle, to build strides, walk
// deltas and the oversize flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ndrt_cfg
    import ndrt_pkg::*;
#(
    parameter int MAX_RANK  = DEF_MAX_RANK,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CIDX_BITS-1:0] cfg_index,
    input  wire logic [SIZE_BITS-1:0] cfg_data,
    output ndrt_ctrl_t                ctrl,
    output logic [IDX_BITS-1:0]       extm1 [(MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES],
    output logic [ADDR_BITS-1:0]      delta [(MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES]
);

    localparam int AXES   = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;
    localparam int PW     = ADDR_BITS + SIZE_BITS;
    localparam int SW     = ADDR_BITS + 2;
    localparam int SPW    = SW + SIZE_BITS;
    localparam logic [SPW-1:0] LIMIT = SPW'(1) << ADDR_BITS;
    localparam logic [SW-1:0]  SAT   = SW'(LIMIT) + SW'(1);

    logic [RANK_BITS-1:0] rank_reg;
    logic [IDX_BITS-1:0]  extm1_reg [AXES];
    logic                 run_reg;
    logic [RANK_BITS-1:0] seq_reg;
    logic [ADDR_BITS-1:0] prod_reg;
    logic [SW-1:0]        psat_reg;
    logic [ADDR_BITS-1:0] stride_reg [AXES+1];
    logic [ADDR_BITS-1:0] stride_r_reg;
    logic [ADDR_BITS-1:0] delta_reg [AXES];
    logic                 oor_reg;

    logic                 wr_ok;
    logic [SIZE_BITS-1:0] ext_sel;
    logic [PW-1:0]        prod_full;
    logic [SPW-1:0]       psat_full;
    logic [SW-1:0]        psat_clip;

    // Writes beyond the register list are dropped without a restart
    assign wr_ok = cfg_valid && (cfg_index <= REG_AXIS3);

    always_comb begin
        ext_sel = '0;
        for (int a = 0; a < AXES; a++) begin
            if (seq_reg == RANK_BITS'(a)) begin
                ext_sel = SIZE_BITS'(extm1_reg[a]) + SIZE_BITS'(1);
            end
        end
        prod_full = PW'(prod_reg) * PW'(ext_sel);
        psat_full = SPW'(psat_reg) * SPW'(ext_sel);
        psat_clip = (psat_full > LIMIT) ? SAT : SW'(psat_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_BITS'(1);
            for (int a = 0; a < AXES; a++) begin
                extm1_reg[a] <= '0;
            end
        end else if (wr_ok) begin
            unique case (cfg_index) inside
                REG_RANK: begin
                    if (cfg_data[RANK_BITS-1:0] == '0) begin
                        rank_reg <= RANK_BITS'(1);
                    end else if (cfg_data[RANK_BITS-1:0] > RANK_BITS'(AXES)) begin
                        rank_reg <= RANK_BITS'(AXES);
                    end else begin
                        rank_reg <= cfg_data[RANK_BITS-1:0];
                    end
                end
                REG_AXIS0, REG_AXIS1, REG_AXIS2, REG_AXIS3: begin
                    for (int a = 0; a < AXES; a++) begin
                        if (cfg_index == REG_AXIS0 + CIDX_BITS'(a)) begin
                            extm1_reg[a] <= ext_m1_f(cfg_data);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Setup sequencer: steps 0..AXES-1 multiply, step AXES forms the deltas
    always_ff @(posedge aclk) begin
        if (!aresetn || wr_ok) begin
            run_reg       <= 1'b1;
            seq_reg       <= '0;
            prod_reg      <= ADDR_BITS'(1);
            psat_reg      <= SW'(1);
            stride_reg[0] <= ADDR_BITS'(1);
        end else if (run_reg) begin
            if (seq_reg == RANK_BITS'(AXES)) begin
                for (int a = 0; a < AXES; a++) begin
                    delta_reg[a] <= stride_reg[a] + stride_reg[a+1] - stride_r_reg;
                end
                oor_reg <= (SPW'(psat_reg) > LIMIT);
                run_reg <= 1'b0;
            end else begin
                prod_reg <= ADDR_BITS'(prod_full);
                for (int a = 0; a < AXES; a++) begin
                    if (seq_reg == RANK_BITS'(a)) begin
                        stride_reg[a+1] <= ADDR_BITS'(prod_full);
                    end
                end
                if (seq_reg < rank_reg) begin
                    psat_reg <= psat_clip;
                end
                if (seq_reg + RANK_BITS'(1) == rank_reg) begin
                    stride_r_reg <= ADDR_BITS'(prod_full);
                end
                seq_reg <= seq_reg + RANK_BITS'(1);
            end
        end
    end

    always_comb begin
        ctrl.busy         = run_reg;
        ctrl.restart      = wr_ok;
        ctrl.out_of_range = oor_reg;
        ctrl.rank         = rank_reg;
        for (int a = 0; a < AXES; a++) begin
            extm1[a] = extm1_reg[a];
            delta[a] = delta_reg[a];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ndrt_walk.sv @@
// ----------------------------------------------------------------------------
// ndrt_walk: per-axis index counters and running destination offset
// Forms one result per accepted element and advances the counters with a
// single carry pass and one add of a precomputed delta.
// ----------------------------------------------------------------------------
`default_nettype none

module ndrt_walk
    import ndrt_pkg::*;
#(
    parameter int MAX_RANK     = DEF_MAX_RANK,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ndrt_ctrl_t              ctrl,
    input  wire logic [IDX_BITS-1:0]     extm1 [(MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES],
    input  wire logic [ADDR_BITS-1:0]    delta [(MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES],
    input  wire logic                    step,
    input  wire logic [ELEMENT_BITS-1:0] element_value,
    output logic [ELEMENT_BITS+ADDR_BITS+1:0] result
);

    localparam int AXES = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;

    logic [IDX_BITS-1:0]  idx_reg [AXES];
    logic [ADDR_BITS-1:0] offset_reg;

    logic [AXES-1:0]      used;
    logic [AXES-1:0]      wrap;
    logic [AXES-1:0]      carry_in;
    logic [AXES-1:0]      inc;
    logic                 all_wrap;
    logic [ADDR_BITS-1:0] add_sel;

    always_comb begin
        all_wrap = 1'b1;
        add_sel  = '0;
        for (int a = AXES - 1; a >= 0; a--) begin
            used[a]     = (RANK_BITS'(a) < ctrl.rank);
            wrap[a]     = (idx_reg[a] == extm1[a]);
            carry_in[a] = all_wrap;
            all_wrap    = all_wrap && (wrap[a] || !used[a]);
        end
        for (int a = 0; a < AXES; a++) begin
            inc[a] = used[a] && carry_in[a] && !wrap[a];
            if (inc[a]) begin
                add_sel = add_sel | delta[a];
            end
        end
    end

    assign result = {element_value, offset_reg, all_wrap, ctrl.out_of_range};

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.restart) begin
            offset_reg <= '0;
            for (int a = 0; a < AXES; a++) begin
                idx_reg[a] <= '0;
            end
        end else if (step) begin
            offset_reg <= all_wrap ? '0 : offset_reg + add_sel;
            for (int a = 0; a < AXES; a++) begin
                if (used[a] && carry_in[a]) begin
                    idx_reg[a] <= wrap[a] ? '0 : idx_reg[a] + IDX_BITS'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ndrt_skid.sv @@
// ----------------------------------------------------------------------------
// ndrt_skid: result register with one skid entry
// Decouples the result channel so that a new transfer is taken while the
// previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module ndrt_skid #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // output slot frees up: drain the skid entry first
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_data_reg  <= in_data;
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_data_reg  <= in_data;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nd_axis_reverse_transpose_addr.sv @@
// ----------------------------------------------------------------------------
// nd_axis_reverse_transpose_addr: scatter addresses for a reversing transpose
// Streams row-major source elements of a rank 1..4 array and tags each with
// its offset in the axis-reversed, row-major destination array.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    s_element_value
//  m_*       out        m_valid / m_ready    m_element_out, m_dest_address,
//                                            m_last_element, m_out_of_range
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One element per cycle while s_ready is high: the counters and offset update
//  with one carry pass and one add; the result is registered in the output
//  register, or in the skid entry if the output is stalled. After reset and
//  every write to a listed register the setup sequencer runs one multiply per
//  axis plus a final delta step with s_ready low; configuration writes are
//  always taken. A stalled m_ready lets one more transfer into the skid entry,
//  then s_ready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module nd_axis_reverse_transpose_addr
    import ndrt_pkg::*;
#(
    parameter int MAX_RANK     = DEF_MAX_RANK,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // element input
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [ELEMENT_BITS-1:0] s_element_value,
    // result output
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [ELEMENT_BITS-1:0]      m_element_out,
    output logic [ADDR_BITS-1:0]         m_dest_address,
    output logic                         m_last_element,
    output logic                         m_out_of_range,
    // register writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CIDX_BITS-1:0]    cfg_index,
    input  wire logic [SIZE_BITS-1:0]    cfg_data
);

    localparam int AXES = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;
    localparam int RW   = ELEMENT_BITS + ADDR_BITS + 2;

    ndrt_ctrl_t           ctrl;
    logic [IDX_BITS-1:0]  extm1 [AXES];
    logic [ADDR_BITS-1:0] delta [AXES];
    logic [RW-1:0]        result;
    logic [RW-1:0]        out_data;
    logic                 skid_ready;
    logic                 step;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    // Hold input while strides are being rebuilt or the skid entry is full
    assign s_ready = skid_ready && !ctrl.busy;
    assign step    = s_valid && s_ready;

    ndrt_cfg #(
        .MAX_RANK  (MAX_RANK),
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .extm1     (extm1),
        .delta     (delta)
    );

    ndrt_walk #(
        .MAX_RANK     (MAX_RANK),
        .ADDR_BITS    (ADDR_BITS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .extm1         (extm1),
        .delta         (delta),
        .step          (step),
        .element_value (s_element_value),
        .result        (result)
    );

    // Advance each accepted transfer into the output register or skid entry
    ndrt_skid #(
        .WIDTH (RW)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step),
        .in_ready  (skid_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_element_out  = out_data[RW-1 -: ELEMENT_BITS];
    assign m_dest_address = out_data[ADDR_BITS+1:2];
    assign m_last_element = out_data[1];
    assign m_out_of_range = out_data[0];

endmodule

`default_nettype wire

@@ test/nd_axis_reverse_transpose_addr_tb.sv @@
// ----------------------------------------------------------------------------
// nd_axis_reverse_transpose_addr_tb: self-checking bench for the scatter block
// Streams source elements through the reversing-transpose address generator
// and checks every result against a behavioral model of the axis counters and
// the destination offset, or a typed-in result. Hand-picked cases run first,
// then random array shapes, with random backpressure and gaps on both sides.
// ----------------------------------------------------------------------------
module nd_axis_reverse_transpose_addr_tb;
    import ndrt_pkg::*;

    localparam int AW               = DEF_ADDR_BITS;
    localparam int EW               = DEF_ELEMENT_BITS;
    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_ITEMS     = 800;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 16;
    localparam int TIMEOUT_CYCLES   = 300000;

    // Indexes past the last register: a write there must change nothing
    localparam logic [CIDX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CIDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam longint unsigned ADDR_SPAN = 64'd1 << AW;

    typedef struct packed {
        logic [EW-1:0] element;
        logic [AW-1:0] address;
        logic          last;
        logic          oor;
    } scatter_t;

    typedef enum logic {ROW_WRITE, ROW_ELEMENT} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CIDX_BITS-1:0] reg_index;
        logic [SIZE_BITS-1:0] reg_data;
        logic [EW-1:0]        element;
        logic                 typed;
        scatter_t             want;
    } directed_row_t;

    typedef enum int {SHAPE_EXTREME, SHAPE_WIDE, SHAPE_SMALL} shape_mix_e;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [EW-1:0]        s_element_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [EW-1:0]        m_element_out;
    logic [AW-1:0]        m_dest_address;
    logic                 m_last_element;
    logic                 m_out_of_range;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CIDX_BITS-1:0] cfg_index;
    logic [SIZE_BITS-1:0] cfg_data;

    // Model state: registers as written, plus the walk over the source array
    logic [RANK_BITS-1:0] shape_rank;
    logic [SIZE_BITS-1:0] shape_size  [NUM_AXES];
    logic [IDX_BITS-1:0]  walk_idx    [NUM_AXES];
    logic [AW-1:0]        walk_stride [NUM_AXES];
    logic [AW-1:0]        walk_offset;

    scatter_t      scatter_expected [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    bit            long_hold_req  = 1'b0;

    nd_axis_reverse_transpose_addr dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_element_out   (m_element_out),
        .m_dest_address  (m_dest_address),
        .m_last_element  (m_last_element),
        .m_out_of_range  (m_out_of_range),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Behavioral model
    // ------------------------------------------------------------------------

    // Clamp a size register to 1..1024
    function automatic int unsigned axis_extent(input int a);
        int unsigned s;
        s = shape_size[a];
        if (s == 0) begin
            s = 1;
        end
        if (s > int'(MAX_EXTENT)) begin
            s = int'(MAX_EXTENT);
        end
        return s;
    endfunction

    // Clamp the rank register to 1..NUM_AXES
    function automatic int unsigned active_rank();
        int unsigned r;
        r = shape_rank;
        if (r < 1) begin
            r = 1;
        end
        if (r > NUM_AXES) begin
            r = NUM_AXES;
        end
        return r;
    endfunction

    // Zero the counters and rebuild the strides: axis a steps the destination
    // by the product of the extents of axes 0..a-1, all modulo the address span
    function automatic void scatter_restart();
        longint unsigned span;
        span = 1;
        for (int a = 0; a < NUM_AXES; a++) begin
            walk_idx[a]    = '0;
            walk_stride[a] = AW'(span);
            span           = (span * axis_extent(a)) % ADDR_SPAN;
        end
        walk_offset = '0;
    endfunction

    function automatic void scatter_config(input logic [CIDX_BITS-1:0] idx,
                                           input logic [SIZE_BITS-1:0] data);
        case (idx)
            REG_RANK: begin
                shape_rank = data[RANK_BITS-1:0];
            end
            REG_AXIS0: begin
                shape_size[0] = data;
            end
            REG_AXIS1: begin
                shape_size[1] = data;
            end
            REG_AXIS2: begin
                shape_size[2] = data;
            end
            REG_AXIS3: begin
                shape_size[3] = data;
            end
            default: begin
                return;
            end
        endcase
        scatter_restart();
    endfunction

    // Tag one element, then advance the counters with carries from the
    // innermost used axis outward
    function automatic scatter_t scatter_next(input logic [EW-1:0] elem);
        scatter_t        res;
        int unsigned     r;
        int              a;
        longint unsigned volume;
        longint unsigned back;
        logic            at_end;
        r      = active_rank();
        volume = 1;
        at_end = 1'b1;
        for (a = 0; a < r; a++) begin
            volume *= axis_extent(a);
            if (walk_idx[a] != axis_extent(a) - 1) begin
                at_end = 1'b0;
            end
        end
        res.element = elem;
        res.address = walk_offset;
        res.last    = at_end;
        res.oor     = (volume > ADDR_SPAN);
        a = r;
        while (a > 0) begin
            a--;
            if (int'(walk_idx[a]) + 1 < axis_extent(a)) begin
                walk_idx[a] = walk_idx[a] + 1'b1;
                walk_offset = walk_offset + walk_stride[a];
                break;
            end
            back        = longint'(walk_idx[a]) * longint'(walk_stride[a]);
            walk_offset = walk_offset - AW'(back);
            walk_idx[a] = '0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [EW-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return EW'($urandom);
            end
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] pick_extent(input shape_mix_e mix);
        if (mix == SHAPE_EXTREME) begin
            case ($urandom_range(0, 5))
                0: return 11'd0;
                1: return 11'd1;
                2: return 11'd1023;
                3: return 11'd1024;
                4: return 11'd1025;
                default: return 11'd2047;
            endcase
        end else if (mix == SHAPE_WIDE) begin
            return SIZE_BITS'($urandom);
        end
        // Keep most arrays tiny so whole traversals and wraps happen often
        return SIZE_BITS'($urandom_range(0, 4));
    endfunction

    task automatic add_write(input logic [CIDX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] data);
        directed_row_t row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_data  = data;
        directed_rows.push_back(row);
    endtask

    task automatic add_element(input logic [EW-1:0] elem);
        directed_row_t row;
        row         = '0;
        row.kind    = ROW_ELEMENT;
        row.element = elem;
        directed_rows.push_back(row);
    endtask

    // Element row with its result typed in by hand
    task automatic add_checked(input logic [EW-1:0] elem, input logic [AW-1:0] addr,
                               input logic last, input logic oor);
        directed_row_t row;
        row              = '0;
        row.kind         = ROW_ELEMENT;
        row.element      = elem;
        row.typed        = 1'b1;
        row.want.element = elem;
        row.want.address = addr;
        row.want.last    = last;
        row.want.oor     = oor;
        directed_rows.push_back(row);
    endtask

    // Offer one element and hold it until the transfer; record what must
    // come back for it
    task automatic offer_element(input logic [EW-1:0] elem, input bit typed,
                                 input scatter_t want);
        scatter_t predicted;
        s_valid         <= 1'b1;
        s_element_value <= elem;
        do @(posedge aclk); while (!s_ready);
        predicted = scatter_next(elem);
        scatter_expected.push_back(typed ? want : predicted);
    endtask

    // Leave cfg_valid high on return; the caller drops it after the batch
    task automatic write_register(input logic [CIDX_BITS-1:0] idx,
                                  input logic [SIZE_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        scatter_config(idx, data);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (scatter_expected.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, random shapes, final report
    // ------------------------------------------------------------------------
    initial begin : stimulus
        directed_row_t row;
        bit            cfg_open;
        bit            steady;
        int            sent;
        int            phase;
        int            count;
        shape_mix_e    mix;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_element_value = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;

        // Registers come out of reset as rank 1 with every extent 1
        shape_rank = RANK_BITS'(1);
        for (int a = 0; a < NUM_AXES; a++) begin
            shape_size[a] = SIZE_BITS'(1);
        end
        scatter_restart();

        // Single-element array after reset: every element is first and last
        add_checked(32'h0000_0000, '0, 1'b1, 1'b0);
        add_checked(32'hFFFF_FFFF, '0, 1'b1, 1'b0);
        // Rank zero acts as rank one; upper data bits do not reach the rank
        add_write(REG_RANK, 11'h7F8);
        add_checked(32'hA5A5_A5A5, '0, 1'b1, 1'b0);
        // Size zero acts as one
        add_write(REG_AXIS0, 11'd0);
        add_checked(32'h5A5A_5A5A, '0, 1'b1, 1'b0);
        // 2x3 source lands in a 3x2 destination: offset = i0 + 2*i1
        add_write(REG_RANK, 11'd2);
        add_write(REG_AXIS0, 11'd2);
        add_write(REG_AXIS1, 11'd3);
        add_checked(32'd1, 20'd0, 1'b0, 1'b0);
        add_checked(32'd2, 20'd2, 1'b0, 1'b0);
        // Unused index: no restart, the walk carries on
        add_write(REG_SPARE_LO, 11'h7FF);
        add_checked(32'd3, 20'd4, 1'b0, 1'b0);
        add_checked(32'd4, 20'd1, 1'b0, 1'b0);
        add_checked(32'd5, 20'd3, 1'b0, 1'b0);
        add_checked(32'd6, 20'd5, 1'b1, 1'b0);
        // End of array wraps back to address zero
        add_checked(32'd7, 20'd0, 1'b0, 1'b0);
        add_write(REG_SPARE_HI, 11'd0);
        add_checked(32'd8, 20'd2, 1'b0, 1'b0);
        // Saturated rank and extents, 2^21 elements: out of range
        add_write(REG_RANK, 11'd7);
        add_write(REG_AXIS0, 11'd2047);
        add_write(REG_AXIS1, 11'd1024);
        add_write(REG_AXIS2, 11'd2);
        add_write(REG_AXIS3, 11'd0);
        add_checked(32'd9, 20'd0, 1'b0, 1'b1);
        add_element(32'd10);
        add_element(32'd11);
        // Exactly 2^20 elements still fits
        add_write(REG_RANK, 11'd2);
        add_checked(32'd12, 20'd0, 1'b0, 1'b0);
        add_element(32'd13);
        add_element(32'd14);
        // Largest shape: every axis at 1024
        add_write(REG_AXIS2, 11'd1024);
        add_write(REG_AXIS3, 11'd1024);
        add_write(REG_RANK, 11'd4);
        add_element(32'h8000_0001);
        add_element(32'h7FFF_FFFE);
        add_element(32'd15);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the table; drain before a batch of writes so the block is idle
        cfg_open = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                if (!cfg_open) begin
                    drain_results();
                end
                write_register(row.reg_index, row.reg_data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                end
                cfg_open = 1'b0;
                offer_element(row.element, row.typed, row.want);
                idle_sender(pick_gap());
            end
        end

        // Random shapes: each phase drains, rewrites some registers (or
        // none, to keep walking the current array), then streams elements
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 5) != 0) begin
                case ($urandom_range(0, 9))
                    0: mix = SHAPE_EXTREME;
                    1: mix = SHAPE_WIDE;
                    default: mix = SHAPE_SMALL;
                endcase
                for (int r = REG_RANK; r <= REG_AXIS3; r++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        if (CIDX_BITS'(r) == REG_RANK) begin
                            write_register(REG_RANK,
                                {8'($urandom), 3'($urandom_range(0, 7))});
                        end else begin
                            write_register(CIDX_BITS'(r), pick_extent(mix));
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    write_register(CIDX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                                   SIZE_BITS'($urandom));
                end
                cfg_valid <= 1'b0;
            end

            count  = $urandom_range(4, 48);
            steady = ($urandom_range(0, 3) == 0);
            // Stall the result side for a long stretch while elements keep
            // coming, so the block fills and holds off its input
            if (phase == 3) begin
                long_hold_req = 1'b1;
                count         = 60;
                steady        = 1'b1;
            end

            for (int k = 0; k < count; k++) begin
                // Pause mid-phase until the block has emptied
                if (phase == 6 && k == count / 2) begin
                    drain_results();
                end
                offer_element(pick_element(), 1'b0, '0);
                sent++;
                if (!steady) begin
                    idle_sender(pick_gap());
                end
            end
            phase++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, runs of steady ready, one long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int run;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall         = LONG_HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            // Cut the run short when a long hold is asked for
            repeat (run) begin
                @(posedge aclk);
                if (long_hold_req) begin
                    break;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        scatter_t want;
        if (aresetn && m_valid && m_ready) begin
            if (scatter_expected.size() == 0) begin
                $error("result transfer with nothing outstanding: dest_address %h",
                       m_dest_address);
                mismatch_count++;
            end else begin
                want = scatter_expected.pop_front();
                if (m_element_out !== want.element) begin
                    $error("element_out: expected %h, got %h", want.element, m_element_out);
                    mismatch_count++;
                end
                if (m_dest_address !== want.address) begin
                    $error("dest_address: expected %h, got %h", want.address, m_dest_address);
                    mismatch_count++;
                end
                if (m_last_element !== want.last) begin
                    $error("last_element: expected %b, got %b", want.last, m_last_element);
                    mismatch_count++;
                end
                if (m_out_of_range !== want.oor) begin
                    $error("out_of_range: expected %b, got %b", want.oor, m_out_of_range);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case a handshake never completes
    initial begin : watchdog
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ndrt_pkg.sv
rtl/core/ndrt_cfg.sv
rtl/core/ndrt_walk.sv
rtl/core/ndrt_skid.sv
rtl/core/nd_axis_reverse_transpose_addr.sv
test/nd_axis_reverse_transpose_addr_tb.sv
